FILE: sv/mvccsv_pkg.sv
// Shared types and constants for the snapshot visibility block.
// Used by the cell and the top level; no dependencies.
package mvccsv_pkg;

  localparam int XID_W   = 32;
  localparam int IDX_W   = 6;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W = 2;

  // func codes carried in s_tuser
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SNAPSHOT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SNAPSHOT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT  = 2'd2;

  // input tdata layout
  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 8;

  // item travelling down the chain of cells
  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] entry_index;
    logic [XID_W-1:0] entry_xid;
    logic [XID_W-1:0] tuple_inserter;
    logic [XID_W-1:0] tuple_deleter;
    logic             ins_below_low;
    logic             ins_below_high;
    logic             del_below_low;
    logic             del_below_high;
    logic             del_nonzero;
    logic             ins_hit;
    logic             del_hit;
  } item_t;

endpackage

FILE: sv/mvccsv_cell.sv
// One cell of the active-list chain: holds one active id and matches passing queries.
// Depends on mvccsv_pkg.
module mvccsv_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          enable,
  input  logic [mvccsv_pkg::COUNT_W-1:0] active_count,
  input  logic                          valid_in,
  input  mvccsv_pkg::item_t             item_in,
  output logic                          valid_out,
  output mvccsv_pkg::item_t             item_out
);

  localparam bit WRITABLE = (CELL_INDEX < (1 << mvccsv_pkg::IDX_W));
  localparam logic [mvccsv_pkg::IDX_W-1:0] SLOT = mvccsv_pkg::IDX_W'(CELL_INDEX);

  logic [mvccsv_pkg::XID_W-1:0] entry;
  logic                         in_use;
  logic                         load_here;
  mvccsv_pkg::item_t            item_next;

  assign in_use    = (32'(CELL_INDEX) < 32'(active_count));
  assign load_here = WRITABLE && valid_in && (item_in.func == mvccsv_pkg::FUNC_LOAD)
                     && (item_in.entry_index == SLOT);

  always_comb begin
    item_next = item_in;
    if (in_use && (entry == item_in.tuple_inserter)) item_next.ins_hit = 1'b1;
    if (in_use && (entry == item_in.tuple_deleter))  item_next.del_hit = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (enable) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      item_out <= item_next;
      if (load_here) entry <= item_in.entry_xid;
    end
  end

endmodule

FILE: sv/mvcc_snapshot_visibility_top.sv
// Top level of the snapshot visibility block: config registers, chain of cells,
// output register. Depends on mvccsv_pkg and mvccsv_cell.
//
// Usage:
//   cfg channel writes snapshot_low (0), snapshot_high (1), active_count (2);
//   cfg_ready is always high, other indexes are dropped. Write only while idle.
//   s_* carries items: s_tuser selects load (0) or query (1). A load stores
//   entry_xid in active list slot entry_index; a query checks a tuple's
//   inserter and deleter ids against the snapshot.
//   m_* returns one result per query and nothing for a load.
// Timing:
//   Every item walks the chain of MAX_ENTRIES cells, one cell per cycle while
//   the chain is not stalled, each cell comparing the passing ids with the
//   active id it stores. A query's result is registered in every cell and in
//   the output register. One item is taken per cycle while the receiver keeps up.
// Reset: clears the registers, the chain and the output valid; active list
//   contents are unknown until loaded.
// Stall: while m_tvalid is high and m_tready low, the whole chain holds and
//   s_tready is low.
module mvcc_snapshot_visibility_top #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mvccsv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mvccsv_pkg::XID_W-1:0]       cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [5:0] entry_index, [37:6] entry_xid, [69:38] tuple_inserter,
  // [101:70] tuple_deleter, [103:102] zero
  input  logic [mvccsv_pkg::S_TDATA_W-1:0]   s_tdata,
  // [0] func
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [0] visible, [1] inserter_committed, [2] deleter_committed, [7:3] zero
  output logic [mvccsv_pkg::M_TDATA_W-1:0]   m_tdata
);

  logic [mvccsv_pkg::XID_W-1:0]   snapshot_low;
  logic [mvccsv_pkg::XID_W-1:0]   snapshot_high;
  logic [mvccsv_pkg::COUNT_W-1:0] active_count;

  logic                enable;
  logic                valid_chain [MAX_ENTRIES+1];
  mvccsv_pkg::item_t   item_chain  [MAX_ENTRIES+1];
  mvccsv_pkg::item_t   head;
  mvccsv_pkg::item_t   tail;
  logic                ins_committed;
  logic                del_committed;

  assign cfg_ready = 1'b1;
  assign enable    = !m_tvalid || m_tready;
  assign s_tready  = enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      snapshot_low  <= '0;
      snapshot_high <= '0;
      active_count  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mvccsv_pkg::CFG_SNAPSHOT_LOW:  snapshot_low  <= cfg_data;
        mvccsv_pkg::CFG_SNAPSHOT_HIGH: snapshot_high <= cfg_data;
        mvccsv_pkg::CFG_ACTIVE_COUNT:  active_count  <= cfg_data[mvccsv_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // bound checks are done once at the head; cells only collect list hits
  always_comb begin
    head.func           = s_tuser;
    head.entry_index    = s_tdata[5:0];
    head.entry_xid      = s_tdata[37:6];
    head.tuple_inserter = s_tdata[69:38];
    head.tuple_deleter  = s_tdata[101:70];
    head.ins_below_low  = (head.tuple_inserter < snapshot_low);
    head.ins_below_high = (head.tuple_inserter < snapshot_high);
    head.del_below_low  = (head.tuple_deleter < snapshot_low);
    head.del_below_high = (head.tuple_deleter < snapshot_high);
    head.del_nonzero    = (head.tuple_deleter != '0);
    head.ins_hit        = 1'b0;
    head.del_hit        = 1'b0;
  end

  assign valid_chain[0] = s_tvalid;
  assign item_chain[0]  = head;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    mvccsv_cell #(.CELL_INDEX(k)) u_cell (
      .clk          (clk),
      .rst          (rst),
      .enable       (enable),
      .active_count (active_count),
      .valid_in     (valid_chain[k]),
      .item_in      (item_chain[k]),
      .valid_out    (valid_chain[k+1]),
      .item_out     (item_chain[k+1])
    );
  end

  assign tail          = item_chain[MAX_ENTRIES];
  assign ins_committed = tail.ins_below_low || (tail.ins_below_high && !tail.ins_hit);
  assign del_committed = tail.del_nonzero &&
                         (tail.del_below_low || (tail.del_below_high && !tail.del_hit));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (enable) begin
      m_tvalid <= valid_chain[MAX_ENTRIES] && (tail.func == mvccsv_pkg::FUNC_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      m_tdata <= {5'b0, del_committed, ins_committed, ins_committed && !del_committed};
    end
  end

endmodule

FILE: sv/mvccsv_checker.sv
// Port-level checker for the snapshot visibility top level, bound to it below.
// Depends only on the top level's ports.
module mvccsv_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [7:0]   m_tdata
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // input side stalls exactly when a result waits
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  // visible means committed inserter and uncommitted deleter; upper bits are zero
  a_visible: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[1] && !m_tdata[2])) && (m_tdata[7:3] == 5'b0))
    else $error("inconsistent visibility flags");

endmodule

bind mvcc_snapshot_visibility_top mvccsv_checker u_mvccsv_checker (.*);
